// File: hw/rtl/brt_pkg.sv
// ----------------------------------------------------------------------------
// brt_pkg
// Shared constants, codes and types of the busy resource table.
// ----------------------------------------------------------------------------
package brt_pkg;

	localparam int DEPTH_DEFAULT = 32;
	localparam int ID_W          = 16;
	localparam int MODE_W        = 3;
	localparam int STATUS_W      = 2;
	localparam int COUNT_OUT_W   = 6;

	// operation codes carried in the mode field
	localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
	localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FIND   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} seq_state_t;

	typedef struct packed {
		logic [ID_W-1:0]        popped_id;
		logic                   hit;
		logic                   verdict;
		logic [STATUS_W-1:0]    status;
		logic                   run_done;
		logic [COUNT_OUT_W-1:0] entry_count;
	} brt_result_t;

endpackage

// File: hw/rtl/brt_mem.sv
// ----------------------------------------------------------------------------
// brt_mem
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module brt_mem #(
	parameter int DEPTH = brt_pkg::DEPTH_DEFAULT,
	parameter int WIDTH = brt_pkg::ID_W,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: hw/rtl/brt_seq.sv
// ----------------------------------------------------------------------------
// brt_seq
// Sequencer: takes one item, walks the stored entries through the memory
// read port on a search, closes the gap on pop and remove and builds the result.
// ----------------------------------------------------------------------------
module brt_seq #(
	parameter int TABLE_DEPTH = brt_pkg::DEPTH_DEFAULT,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [brt_pkg::MODE_W-1:0]   mode,
	input  logic [brt_pkg::ID_W-1:0]     resource_id,
	input  logic                         first_of_run,
	input  logic                         last_of_run,
	input  logic                         out_free,
	output logic                         res_valid,
	output brt_pkg::brt_result_t         res,
	output logic                         mem_rd_en,
	output logic [AW-1:0]                mem_rd_addr,
	input  logic [brt_pkg::ID_W-1:0]     mem_rd_data,
	output logic                         mem_wr_en,
	output logic [AW-1:0]                mem_wr_addr,
	output logic [brt_pkg::ID_W-1:0]     mem_wr_data
);

	brt_pkg::seq_state_t state_q, state_d;

	logic [brt_pkg::MODE_W-1:0]   mode_q;
	logic [brt_pkg::ID_W-1:0]     id_q;
	logic                         last_q;
	logic [brt_pkg::STATUS_W-1:0] status_q;
	logic [brt_pkg::ID_W-1:0]     popped_q;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                rd_idx_q;
	logic                         verdict_q;
	logic                         found_q;
	logic                         rv_s1;
	logic [AW-1:0]                idx_s1;

	logic                         accept;
	logic                         is_run;
	logic                         run_q;
	logic                         verdict_eff;
	logic                         scan_end;
	logic                         match;
	logic                         shifting;
	logic                         table_full;
	logic [CW-1:0]                count_next;
	logic                         verdict_new;
	logic [CW+brt_pkg::COUNT_OUT_W-1:0] count_wide;

	assign in_ready    = (state_q == brt_pkg::ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign is_run      = (mode == brt_pkg::MODE_CHECK) || (mode == brt_pkg::MODE_REMOVE);
	assign run_q       = (mode_q == brt_pkg::MODE_CHECK) || (mode_q == brt_pkg::MODE_REMOVE);
	assign verdict_eff = first_of_run || verdict_q;
	assign table_full  = (count_q == CW'(TABLE_DEPTH));
	assign shifting    = (mode_q == brt_pkg::MODE_POP) || (mode_q == brt_pkg::MODE_REMOVE);

	// walk the stored entries, one read per cycle
	assign mem_rd_en   = (state_q == brt_pkg::ST_SCAN) && (rd_idx_q < count_q);
	assign mem_rd_addr = rd_idx_q[AW-1:0];
	assign scan_end    = (state_q == brt_pkg::ST_SCAN) && !mem_rd_en && !rv_s1;

	// pop takes the head; the others look for the oldest equal entry
	assign match = (mode_q == brt_pkg::MODE_POP) ? (idx_s1 == '0) : (mem_rd_data == id_q);

	// write port: append at the tail, or move an entry down one place
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = count_q[AW-1:0];
		mem_wr_data = resource_id;
		if (accept && (mode == brt_pkg::MODE_APPEND) && !table_full) begin
			mem_wr_en = 1'b1;
		end else if (rv_s1 && shifting && found_q) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = AW'(idx_s1 - 1'b1);
			mem_wr_data = mem_rd_data;
		end
	end

	// fill count and verdict after this item
	always_comb begin
		count_next  = count_q;
		verdict_new = verdict_q;
		unique case (mode_q)
			brt_pkg::MODE_APPEND: begin
				if (status_q == brt_pkg::STATUS_OK) begin
					count_next = count_q + 1'b1;
				end
			end
			brt_pkg::MODE_POP: begin
				if (found_q) begin
					count_next = count_q - 1'b1;
				end
			end
			brt_pkg::MODE_CHECK: begin
				verdict_new = verdict_q && !found_q;
			end
			brt_pkg::MODE_REMOVE: begin
				verdict_new = verdict_q && found_q;
				if (found_q) begin
					count_next = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// assemble the result
	always_comb begin
		count_wide      = {{brt_pkg::COUNT_OUT_W{1'b0}}, count_next};
		res.popped_id   = ((mode_q == brt_pkg::MODE_POP) && found_q) ? popped_q : '0;
		res.hit         = found_q && ((mode_q == brt_pkg::MODE_FIND) || run_q);
		res.verdict     = run_q && verdict_new;
		res.status      = status_q;
		res.run_done    = run_q && last_q;
		res.entry_count = count_wide[brt_pkg::COUNT_OUT_W-1:0];
	end

	// next state
	always_comb begin
		state_d   = state_q;
		res_valid = 1'b0;
		unique case (state_q)
			brt_pkg::ST_IDLE: begin
				if (accept) begin
					priority if ((mode == brt_pkg::MODE_POP) || (mode == brt_pkg::MODE_FIND) ||
						(mode == brt_pkg::MODE_CHECK)) begin
						state_d = brt_pkg::ST_SCAN;
					end else if ((mode == brt_pkg::MODE_REMOVE) && verdict_eff) begin
						state_d = brt_pkg::ST_SCAN;
					end else begin
						state_d = brt_pkg::ST_FINISH;
					end
				end
			end
			brt_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = brt_pkg::ST_FINISH;
				end
			end
			brt_pkg::ST_FINISH: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = brt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = brt_pkg::ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= brt_pkg::ST_IDLE;
			count_q   <= '0;
			verdict_q <= 1'b1;
			found_q   <= 1'b0;
			rd_idx_q  <= '0;
			rv_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1   <= mem_rd_en;
			if (accept) begin
				rd_idx_q <= '0;
				found_q  <= 1'b0;
				if (is_run) begin
					verdict_q <= verdict_eff;
				end
			end
			if (mem_rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (rv_s1 && match) begin
				found_q <= 1'b1;
			end
			if (res_valid) begin
				count_q   <= count_next;
				verdict_q <= verdict_new;
			end
		end
	end

	// item payload and scan pipeline
	always_ff @(posedge clk) begin
		idx_s1 <= mem_rd_addr;
		if (accept) begin
			mode_q <= mode;
			id_q   <= resource_id;
			last_q <= last_of_run;
			if ((mode == brt_pkg::MODE_APPEND) && table_full) begin
				status_q <= brt_pkg::STATUS_FULL;
			end else if ((mode == brt_pkg::MODE_POP) && (count_q == '0)) begin
				status_q <= brt_pkg::STATUS_EMPTY;
			end else begin
				status_q <= brt_pkg::STATUS_OK;
			end
		end
		if (rv_s1 && match && !found_q) begin
			popped_q <= mem_rd_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_shift_after_match: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr_en && (state_q == brt_pkg::ST_SCAN)) |-> found_q)
		else $error("entry moved before a match");

	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (state_q == brt_pkg::ST_IDLE))
		else $error("sequencer not idle after result");

	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (mode_q == brt_pkg::MODE_APPEND) &&
		(status_q == brt_pkg::STATUS_OK)) |=> (count_q == $past(count_q) + 1'b1))
		else $error("append did not advance fill count");

endmodule

// File: hw/rtl/busy_resource_table_top.sv
// ----------------------------------------------------------------------------
// busy_resource_table_top
// Ordered table of busy resource identifiers with append, pop, find and
// demand-run check and remove, held in one synchronous memory.
// ----------------------------------------------------------------------------
// Flow: append, unused modes and a remove whose run verdict is already zero
// go straight to the finish state; pop, find, check and other removes walk
// the memory read port once over the stored entries to build the result.
// One item at a time: a new item is taken only once the sequencer is idle;
// a result waiting in the output register does not block the next item.
// Reset: the table is empty and the run verdict is one; no clearing pass.
// ----------------------------------------------------------------------------
module busy_resource_table_top #(
	parameter int TABLE_DEPTH = brt_pkg::DEPTH_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [brt_pkg::MODE_W-1:0]         mode,
	input  logic [brt_pkg::ID_W-1:0]           resource_id,
	input  logic                               first_of_run,
	input  logic                               last_of_run,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [brt_pkg::ID_W-1:0]           popped_id,
	output logic                               hit,
	output logic                               verdict,
	output logic [brt_pkg::STATUS_W-1:0]       status,
	output logic                               run_done,
	output logic [brt_pkg::COUNT_OUT_W-1:0]    entry_count
);

	localparam int AW = $clog2(TABLE_DEPTH);

	logic                     mem_rd_en;
	logic [AW-1:0]            mem_rd_addr;
	logic [brt_pkg::ID_W-1:0] mem_rd_data;
	logic                     mem_wr_en;
	logic [AW-1:0]            mem_wr_addr;
	logic [brt_pkg::ID_W-1:0] mem_wr_data;

	logic                     res_valid;
	brt_pkg::brt_result_t     res;
	brt_pkg::brt_result_t     res_q;
	logic                     out_valid_q;
	logic                     out_free;

	brt_mem #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (brt_pkg::ID_W)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	brt_seq #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.resource_id  (resource_id),
		.first_of_run (first_of_run),
		.last_of_run  (last_of_run),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res          (res),
		.mem_rd_en    (mem_rd_en),
		.mem_rd_addr  (mem_rd_addr),
		.mem_rd_data  (mem_rd_data),
		.mem_wr_en    (mem_wr_en),
		.mem_wr_addr  (mem_wr_addr),
		.mem_wr_data  (mem_wr_data)
	);

	// output register: free when empty or being taken
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the item until it is taken
	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign popped_id   = res_q.popped_id;
	assign hit         = res_q.hit;
	assign verdict     = res_q.verdict;
	assign status      = res_q.status;
	assign run_done    = res_q.run_done;
	assign entry_count = res_q.entry_count;

endmodule
